// ===== hw/rtl/tcce_pkg.sv =====
package tcce_pkg;

	// Result actions
	typedef enum logic [1:0] {
		ACT_DRAW   = 2'd0,
		ACT_SCROLL = 2'd1,
		ACT_CLEAR  = 2'd2,
		ACT_NONE   = 2'd3
	} act_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MOD,
		ST_WRAP,
		ST_DRAW,
		ST_END
	} state_t;

	// Configuration register indexes
	localparam logic [2:0] REG_SCREEN_COLUMNS = 3'd0;
	localparam logic [2:0] REG_SCREEN_ROWS    = 3'd1;
	localparam logic [2:0] REG_TAB_SIZE       = 3'd2;
	localparam logic [2:0] REG_WRAP_ENABLE    = 3'd3;
	localparam logic [2:0] REG_GLYPH_COUNT    = 3'd4;

	// Input modes
	localparam logic MODE_CHAR  = 1'b0;
	localparam logic MODE_CLEAR = 1'b1;

	// Control bytes
	localparam logic [7:0] CHAR_TAB     = 8'h09;
	localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
	localparam logic [7:0] CHAR_RETURN  = 8'h0D;
	localparam logic [7:0] CHAR_SPACE   = 8'h20;

	localparam int RESULT_LIMIT = 32;
	localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);

	// One result item, action in the lowest bits
	typedef struct packed {
		logic [8:0] glyph_index;
		logic [6:0] cell_row;
		logic [7:0] cell_column;
		act_t       action;
	} res_t;

endpackage

// ===== hw/rtl/text_console_cursor_engine_top.sv =====
// Text console cursor engine.
//
// Input stream (s_axis): one transfer per console item. tuser carries the mode
// (0 character byte, 1 clear screen and home cursor), tdata carries the byte.
// Output stream (m_axis): display commands, one per transfer: draw a glyph cell,
// scroll up one row, clear screen, or none. tlast marks the final command of an
// item; every item gives at least one command and at most 32.
// Configuration: cfg_wr_en writes cfg_data into register cfg_index (0 columns,
// 1 rows, 2 tab size, 3 wrap enable, 4 glyph count). Write only while idle.
//
// Sequencing: one item at a time. A clear, newline or carriage return passes
// the decode and end states before its command is loaded into the output.
// A plain character passes decode, wrap check, draw and end. A tab runs a
// bit-serial remainder of the cursor column by the tab size and then two
// steps (wrap check, draw) per space. The input is ready again once the final
// command sits in the output register.
// Reset clears the cursor to (0, 0), loads the register defaults and empties
// the output. A stalled receiver holds the output register; the sequencer then
// waits on the one held-back command until the output frees.
module text_console_cursor_engine_top
	import tcce_pkg::*;
#(
	parameter int MAX_TAB_SIZE = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] character
	input  logic        s_axis_tuser,   // [0] mode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [1:0] action, [9:2] cell_column,
	                                    // [16:10] cell_row, [25:17] glyph_index
	output logic        m_axis_tlast,
	input  logic        cfg_wr_en,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	localparam int TW = $clog2(MAX_TAB_SIZE + 1);

	// Configuration registers
	logic [7:0] columns_q;
	logic [6:0] rows_q;
	logic [4:0] tab_size_q;
	logic       wrap_en_q;
	logic [9:0] glyph_count_q;

	// Cursor and sequencer state
	state_t          state_q, state_d;
	logic [7:0]      col_q;
	logic [6:0]      row_q;
	logic [TW-1:0]   pending_q;
	logic            wrapped_q;
	logic [CNT_W-1:0] cnt_q;

	// Item and remainder unit
	logic            mode_q;
	logic [7:0]      char_q;
	logic [8:0]      glyph_q;
	logic [TW-1:0]   tab_q;
	logic [TW-1:0]   rem_q;
	logic [2:0]      bit_idx_q;

	// Held-back result and output register
	res_t hold_q;
	logic hold_v_q;
	res_t out_q;
	logic out_v_q;
	logic out_last_q;

	// Combinational signals
	logic          out_free;
	logic          gen_v;
	res_t          gen_res;
	logic          gen_ok;
	logic          stall;
	logic          wrap_go;
	logic [6:0]    row_inc;
	logic          row_over;
	logic [6:0]    row_stepped;
	logic [TW:0]   rem_shift;
	logic          rem_ge;
	logic [TW-1:0] rem_next;
	logic [TW-1:0] tab_eff;
	logic [7:0]    sel_char;
	logic [8:0]    glyph_sel;
	logic          draw_done;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {6'd0, out_q};
	assign m_axis_tlast  = out_last_q;

	assign out_free = !out_v_q || m_axis_tready;

	// Row step: saturate at 127, then pull back one row and scroll on overflow
	assign row_inc     = (row_q != 7'h7F) ? row_q + 7'd1 : row_q;
	assign row_over    = (row_inc >= rows_q);
	assign row_stepped = (row_over && row_inc != 7'd0) ? row_inc - 7'd1 : row_inc;

	// Subtract-compare unit for the tab remainder: one remainder bit per cycle
	assign rem_shift = {rem_q, col_q[bit_idx_q]};
	assign rem_ge    = (rem_shift >= {1'b0, tab_q});
	assign rem_next  = rem_ge ? TW'(rem_shift - {1'b0, tab_q}) : TW'(rem_shift);

	// Tab size 0 acts as 1, above the maximum as the maximum
	always_comb begin
		if (tab_size_q == 5'd0) begin
			tab_eff = TW'(1);
		end else if (int'(tab_size_q) > MAX_TAB_SIZE) begin
			tab_eff = TW'(MAX_TAB_SIZE);
		end else begin
			tab_eff = TW'({1'b0, tab_size_q});
		end
	end

	// Glyph choice: the byte (space for a tab) if 1..127 and inside the font, else glyph 0
	assign sel_char  = (char_q == CHAR_TAB) ? CHAR_SPACE : char_q;
	assign glyph_sel = (sel_char != 8'd0 && !sel_char[7] &&
	                    {2'b00, sel_char} < glyph_count_q) ? {1'b0, sel_char} : 9'd0;

	assign draw_done = wrapped_q || (pending_q == TW'(1));

	// Result generation per state
	always_comb begin
		gen_v   = 1'b0;
		gen_res = '{glyph_index: 9'd0, cell_row: 7'd0, cell_column: 8'd0,
		            action: ACT_NONE};
		wrap_go = wrap_en_q && (col_q >= columns_q);
		unique case (state_q)
			ST_DECODE: begin
				if (mode_q == MODE_CLEAR) begin
					gen_v          = 1'b1;
					gen_res.action = ACT_CLEAR;
				end else if (char_q == CHAR_NEWLINE) begin
					gen_v          = row_over;
					gen_res.action = ACT_SCROLL;
				end
			end
			ST_WRAP: begin
				gen_v          = wrap_go && row_over;
				gen_res.action = ACT_SCROLL;
			end
			ST_DRAW: begin
				gen_v               = (col_q < columns_q);
				gen_res.action      = ACT_DRAW;
				gen_res.cell_column = col_q;
				gen_res.cell_row    = row_q;
				gen_res.glyph_index = glyph_q;
			end
			default: begin
			end
		endcase
	end

	// Results beyond the limit are dropped and never stall
	assign gen_ok = gen_v && (cnt_q < CNT_W'(RESULT_LIMIT));
	assign stall  = gen_ok && hold_v_q && !out_free;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_axis_tvalid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (mode_q == MODE_CLEAR || char_q == CHAR_NEWLINE ||
				    char_q == CHAR_RETURN) begin
					state_d = ST_END;
				end else if (char_q == CHAR_TAB) begin
					state_d = ST_MOD;
				end else begin
					state_d = ST_WRAP;
				end
			end
			ST_MOD: begin
				if (bit_idx_q == 3'd0) begin
					state_d = ST_WRAP;
				end
			end
			ST_WRAP: begin
				if (!stall) begin
					state_d = ST_DRAW;
				end
			end
			ST_DRAW: begin
				if (!stall) begin
					state_d = draw_done ? ST_END : ST_WRAP;
				end
			end
			ST_END: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			columns_q     <= 8'd160;
			rows_q        <= 7'd45;
			tab_size_q    <= 5'd4;
			wrap_en_q     <= 1'b0;
			glyph_count_q <= 10'd256;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_SCREEN_COLUMNS: columns_q     <= cfg_data[7:0];
				REG_SCREEN_ROWS:    rows_q        <= cfg_data[6:0];
				REG_TAB_SIZE:       tab_size_q    <= cfg_data[4:0];
				REG_WRAP_ENABLE:    wrap_en_q     <= cfg_data[0];
				REG_GLYPH_COUNT:    glyph_count_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Control state: sequencer, cursor, result bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_q     <= 8'd0;
			row_q     <= 7'd0;
			pending_q <= '0;
			wrapped_q <= 1'b0;
			cnt_q     <= '0;
			hold_v_q  <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			state_q <= state_d;

			// Drain the output register on a transfer
			if (out_v_q && m_axis_tready) begin
				out_v_q <= 1'b0;
			end

			// Keep one result back so the final one can carry tlast
			if (gen_ok && !stall) begin
				hold_v_q <= 1'b1;
				cnt_q    <= cnt_q + CNT_W'(1);
				if (hold_v_q) begin
					out_v_q <= 1'b1;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					cnt_q     <= '0;
					wrapped_q <= 1'b0;
				end
				ST_DECODE: begin
					if (mode_q == MODE_CLEAR) begin
						col_q <= 8'd0;
						row_q <= 7'd0;
					end else if (char_q == CHAR_NEWLINE) begin
						col_q <= 8'd0;
						row_q <= row_stepped;
					end else if (char_q == CHAR_RETURN) begin
						col_q <= 8'd0;
					end else if (char_q != CHAR_TAB) begin
						pending_q <= TW'(1);
					end
				end
				ST_MOD: begin
					if (bit_idx_q == 3'd0) begin
						pending_q <= tab_q - rem_next;
					end
				end
				ST_WRAP: begin
					if (!stall) begin
						wrapped_q <= wrap_go;
						if (wrap_go) begin
							col_q <= 8'd0;
							row_q <= row_stepped;
						end
					end
				end
				ST_DRAW: begin
					if (!stall) begin
						pending_q <= pending_q - TW'(1);
						if (col_q != 8'hFF) begin
							col_q <= col_q + 8'd1;
						end
					end
				end
				ST_END: begin
					if (out_free) begin
						hold_v_q <= 1'b0;
						out_v_q  <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			mode_q <= s_axis_tuser;
			char_q <= s_axis_tdata;
		end

		if (state_q == ST_DECODE) begin
			glyph_q   <= glyph_sel;
			tab_q     <= tab_eff;
			rem_q     <= '0;
			bit_idx_q <= 3'd7;
		end else if (state_q == ST_MOD) begin
			rem_q     <= rem_next;
			bit_idx_q <= bit_idx_q - 3'd1;
		end

		if (gen_ok && !stall) begin
			hold_q <= gen_res;
			if (hold_v_q) begin
				out_q      <= hold_q;
				out_last_q <= 1'b0;
			end
		end

		if (state_q == ST_END && out_free) begin
			out_last_q <= 1'b1;
			if (hold_v_q) begin
				out_q <= hold_q;
			end else begin
				out_q <= '{glyph_index: 9'd0, cell_row: 7'd0, cell_column: 8'd0,
				           action: ACT_NONE};
			end
		end
	end

endmodule

// ===== hw/rtl/tcce_checker.sv =====
module tcce_checker
	import tcce_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic        m_axis_tlast
);

	logic       in_xfer;
	logic       last_xfer;
	logic [1:0] open_q;

	assign in_xfer   = s_axis_tvalid && s_axis_tready;
	assign last_xfer = m_axis_tvalid && m_axis_tready && m_axis_tlast;

	// Items taken whose final command has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 2'd0;
		end else if (in_xfer && !last_xfer) begin
			open_q <= open_q + 2'd1;
		end else if (!in_xfer && last_xfer) begin
			open_q <= open_q - 2'd1;
		end
	end

	// One item at a time: the input closes after a transfer
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> !s_axis_tready)
		else $error("input still ready after a transfer");

	// A stalled command holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output changed under stall");

	// tlast only closes an item that was taken
	a_last_owned: assert property (@(posedge clk) disable iff (!arst_n)
		last_xfer |-> (open_q != 2'd0))
		else $error("tlast without an open item");

	// At most the waiting final command and one item in work
	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		open_q != 2'd3)
		else $error("too many open items");

	// Scroll, clear and none carry zero coordinates and glyph
	a_nondraw_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[1:0] != ACT_DRAW) |-> (m_axis_tdata[25:2] == 24'd0))
		else $error("non-draw command with nonzero fields");

endmodule

bind text_console_cursor_engine_top tcce_checker u_tcce_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

// ===== test/tb_text_console_cursor_engine_top.sv =====
`timescale 1ns / 1ps

module tb_text_console_cursor_engine_top;
	import tcce_pkg::*;

	localparam int MAX_TAB = 16;

	// One expected display command, as it leaves the master side
	typedef struct {
		act_t       action;
		logic [7:0] cell_column;
		logic [6:0] cell_row;
		logic [8:0] glyph_index;
		logic       last;
	} cmd_t;

	logic        clk;
	logic        arst_n        = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] character
	logic        s_axis_tuser  = 1'b0;   // [0] mode
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // [1:0] action, [9:2] cell_column,
	                                     // [16:10] cell_row, [25:17] glyph_index
	logic        m_axis_tlast;
	logic        cfg_wr_en     = 1'b0;
	logic [2:0]  cfg_index     = 3'd0;
	logic [9:0]  cfg_data      = 10'd0;

	// Shadow copy of the registers, loaded with the reset defaults
	logic [7:0] scr_cols  = 8'd160;
	logic [6:0] scr_rows  = 7'd45;
	logic [4:0] tab_size  = 5'd4;
	logic       wrap_en   = 1'b0;
	logic [9:0] glyph_cnt = 10'd256;

	// Predicted cursor
	logic [7:0] cur_col = 8'd0;
	logic [6:0] cur_row = 7'd0;

	cmd_t item_cmds[$];       // commands of the item being predicted
	cmd_t expected_cmds[$];   // commands still to come out of the block

	int fail_count       = 0;
	int src_idle_pct     = 37;
	int sink_idle_pct    = 37;
	int sink_hold_cycles = 0;

	text_console_cursor_engine_top #(
		.MAX_TAB_SIZE(MAX_TAB)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------
	// Cursor predictor
	// ------------------------------------------------------------------

	// Queue one command for the current item; drop anything past the limit.
	function void emit_cmd(act_t act, logic [7:0] col, logic [6:0] row, logic [8:0] glyph);
		cmd_t cmd;
		if (item_cmds.size() >= RESULT_LIMIT)
			return;
		cmd.action      = act;
		cmd.cell_column = col;
		cmd.cell_row    = row;
		cmd.glyph_index = glyph;
		cmd.last        = 1'b0;
		item_cmds.push_back(cmd);
	endfunction

	// Move down one row; on overflow step back once and scroll.
	function void step_row();
		if (cur_row < 7'd127)
			cur_row = cur_row + 7'd1;
		if (cur_row >= scr_rows) begin
			if (cur_row > 7'd0)
				cur_row = cur_row - 7'd1;
			emit_cmd(ACT_SCROLL, 8'd0, 7'd0, 9'd0);
		end
	endfunction

	// Write one glyph cell at the cursor; return 1 when the cursor wrapped first.
	function bit put_cell(logic [7:0] ch);
		bit         wrapped;
		logic [8:0] glyph;
		wrapped = 1'b0;
		if (wrap_en && cur_col >= scr_cols) begin
			cur_col = 8'd0;
			step_row();
			wrapped = 1'b1;
		end
		if (cur_col < scr_cols) begin
			glyph = (ch >= 8'd1 && ch <= 8'd127 && {2'b00, ch} < glyph_cnt) ? {1'b0, ch} : 9'd0;
			emit_cmd(ACT_DRAW, cur_col, cur_row, glyph);
		end
		if (cur_col < 8'd255)
			cur_col = cur_col + 8'd1;
		return wrapped;
	endfunction

	// Advance the cursor for one accepted item and queue its commands.
	function void predict_cursor_cmds(logic mode, logic [7:0] ch);
		logic [4:0] stop;
		int         spaces;
		item_cmds.delete();
		if (mode == MODE_CLEAR) begin
			cur_col = 8'd0;
			cur_row = 7'd0;
			emit_cmd(ACT_CLEAR, 8'd0, 7'd0, 9'd0);
		end else if (ch == CHAR_NEWLINE) begin
			cur_col = 8'd0;
			step_row();
		end else if (ch == CHAR_RETURN) begin
			cur_col = 8'd0;
		end else if (ch == CHAR_TAB) begin
			// zero acts as one, anything above the maximum as the maximum
			stop = (tab_size == 5'd0) ? 5'd1 : ((tab_size > MAX_TAB) ? 5'(MAX_TAB) : tab_size);
			spaces = int'(stop) - int'(cur_col % stop);
			while (spaces > 0) begin
				spaces--;
				if (put_cell(CHAR_SPACE))
					spaces = 0;
			end
		end else begin
			void'(put_cell(ch));
		end
		if (item_cmds.size() == 0)
			emit_cmd(ACT_NONE, 8'd0, 7'd0, 9'd0);
		item_cmds[item_cmds.size() - 1].last = 1'b1;
		foreach (item_cmds[i])
			expected_cmds.push_back(item_cmds[i]);
	endfunction

	// ------------------------------------------------------------------
	// Receiver: random stalls, plus a counted hold-off on request
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (sink_hold_cycles > 0) begin
			m_axis_tready <= 1'b0;
			sink_hold_cycles--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	function void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Compare every accepted command with the oldest expectation
	always @(posedge clk) begin : cmd_checker
		cmd_t want;
		res_t got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = res_t'(m_axis_tdata[25:0]);
			if (expected_cmds.size() == 0) begin
				$error("unexpected command: tdata %h, tlast %b", m_axis_tdata, m_axis_tlast);
				fail_count++;
			end else begin
				want = expected_cmds.pop_front();
				check_field("action", want.action, got.action);
				check_field("cell_column", want.cell_column, got.cell_column);
				check_field("cell_row", want.cell_row, got.cell_row);
				check_field("glyph_index", want.glyph_index, got.glyph_index);
				check_field("last", want.last, m_axis_tlast);
			end
		end
	end

	// ------------------------------------------------------------------
	// Sender and configuration
	// ------------------------------------------------------------------

	// Offer one item and hold it until the transfer; tvalid stays high after
	// the transfer so the next item can follow back to back.
	task send_console_item(input logic mode, input logic [7:0] ch);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= ch;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_cursor_cmds(mode, ch);
	endtask

	// Drop tvalid, wait for every expected command, then let the block settle.
	task wait_drained();
		s_axis_tvalid <= 1'b0;
		while (expected_cmds.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task write_reg(input logic [2:0] idx, input logic [9:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_SCREEN_COLUMNS: scr_cols  = val[7:0];
			REG_SCREEN_ROWS:    scr_rows  = val[6:0];
			REG_TAB_SIZE:       tab_size  = val[4:0];
			REG_WRAP_ENABLE:    wrap_en   = val[0];
			REG_GLYPH_COUNT:    glyph_cnt = val;
			default: ;
		endcase
		@(posedge clk);
	endtask

	// Write all five registers once the block is idle.
	task configure(input logic [7:0] cols, input logic [6:0] rows, input logic [4:0] tab,
	               input logic wrap, input logic [9:0] glyphs);
		wait_drained();
		write_reg(REG_SCREEN_COLUMNS, {2'b00, cols});
		write_reg(REG_SCREEN_ROWS, {3'b000, rows});
		write_reg(REG_TAB_SIZE, {5'b00000, tab});
		write_reg(REG_WRAP_ENABLE, {9'd0, wrap});
		write_reg(REG_GLYPH_COUNT, glyphs);
	endtask

	// Mostly text with line breaks, tabs and clears, some raw bytes of any value.
	task send_random_item();
		int pick;
		pick = $urandom_range(99);
		if (pick < 5)
			send_console_item(MODE_CLEAR, 8'($urandom));
		else if (pick < 15)
			send_console_item(MODE_CHAR, CHAR_NEWLINE);
		else if (pick < 22)
			send_console_item(MODE_CHAR, CHAR_RETURN);
		else if (pick < 37)
			send_console_item(MODE_CHAR, CHAR_TAB);
		else if (pick < 80)
			send_console_item(MODE_CHAR, 8'($urandom_range(8'h20, 8'h7E)));
		else
			send_console_item(MODE_CHAR, 8'($urandom));
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset defaults: glyph edges, control bytes and clear
	task test_defaults();
		send_console_item(MODE_CHAR, 8'h41);
		send_console_item(MODE_CHAR, 8'h00);
		send_console_item(MODE_CHAR, 8'h01);
		send_console_item(MODE_CHAR, 8'h7F);
		send_console_item(MODE_CHAR, 8'h80);
		send_console_item(MODE_CHAR, 8'hFF);
		send_console_item(MODE_CHAR, CHAR_RETURN);
		send_console_item(MODE_CHAR, CHAR_TAB);
		send_console_item(MODE_CHAR, CHAR_NEWLINE);
		send_console_item(MODE_CLEAR, 8'hFF);
	endtask

	// One-cell screen with wrap: later writes wrap and scroll, a tab ends on wrap
	task test_narrow_screen();
		configure(8'd1, 7'd1, 5'd16, 1'b1, 10'd1);
		send_console_item(MODE_CHAR, 8'h42);
		send_console_item(MODE_CHAR, 8'h78);
		send_console_item(MODE_CHAR, CHAR_TAB);
		send_console_item(MODE_CHAR, CHAR_NEWLINE);
		configure(8'd255, 7'd127, 5'd1, 1'b0, 10'd512);
		send_console_item(MODE_CHAR, 8'h7F);
		send_console_item(MODE_CHAR, 8'h80);
		send_console_item(MODE_CHAR, CHAR_TAB);
	endtask

	// Zero columns, rows, tab size and glyph count
	task test_zero_sizes();
		configure(8'd0, 7'd0, 5'd0, 1'b1, 10'd0);
		send_console_item(MODE_CHAR, 8'h41);
		send_console_item(MODE_CHAR, CHAR_TAB);
		send_console_item(MODE_CHAR, CHAR_NEWLINE);
		send_console_item(MODE_CHAR, CHAR_RETURN);
		configure(8'd0, 7'd0, 5'd0, 1'b0, 10'd0);
		send_console_item(MODE_CHAR, 8'h41);
		send_console_item(MODE_CHAR, CHAR_TAB);
	endtask

	// Random settings, extremes mixed in
	task test_random_mix();
		logic [7:0] cols;
		logic [6:0] rows;
		for (int phase = 0; phase < 3; phase++) begin
			case ($urandom_range(3))
				0:       cols = 8'd1;
				1:       cols = 8'd255;
				default: cols = 8'($urandom_range(2, 24));
			endcase
			case ($urandom_range(3))
				0:       rows = 7'd1;
				1:       rows = 7'd127;
				default: rows = 7'($urandom_range(2, 10));
			endcase
			configure(cols, rows, 5'($urandom_range(0, 31)), 1'($urandom),
			          10'($urandom_range(0, 1023)));
			repeat (24) send_random_item();
		end
	endtask

	// Long lines with wrap off: tab runs push the column counter to saturation
	task test_long_lines();
		configure(8'($urandom_range(1, 40)), 7'($urandom_range(1, 5)),
		          5'(16 + $urandom_range(0, 15)), 1'b0, 10'($urandom_range(0, 1023)));
		send_console_item(MODE_CHAR, CHAR_RETURN);
		repeat (24) begin
			if ($urandom_range(99) < 75)
				send_console_item(MODE_CHAR, CHAR_TAB);
			else
				send_console_item(MODE_CHAR, 8'($urandom_range(8'h20, 8'hFF)));
		end
	endtask

	// Receiver holds off while the sender keeps offering; the input must stall
	task test_output_backpressure();
		configure(8'd8, 7'd3, 5'd8, 1'b1, 10'd128);
		sink_hold_cycles = 400;
		repeat (20) send_random_item();
	endtask

	// Both sides without idle cycles
	task test_no_idle();
		wait_drained();
		src_idle_pct  = 0;
		sink_idle_pct = 0;
		configure(8'd12, 7'd4, 5'd5, 1'b1, 10'd100);
		repeat (30) send_random_item();
		wait_drained();
		src_idle_pct  = 37;
		sink_idle_pct = 37;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_defaults();
		test_narrow_screen();
		test_zero_sizes();
		test_random_mix();
		test_long_lines();
		test_output_backpressure();
		test_no_idle();

		// Drain, then give stray commands a chance to show up
		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("text_console_cursor_engine_top: match");
		else
			$display("text_console_cursor_engine_top: mismatch");
		$finish;
	end

	// Watchdog far beyond the slowest correct run
	initial begin
		#5000000;
		$display("text_console_cursor_engine_top: mismatch");
		$finish;
	end

endmodule
